// ===== sv/cpu_accumulator_alu_with_flags_defines.svh =====
// assertion macros for the accumulator alu top level
// expects clk and rst_n in the scope of each use
`ifndef CPU_ACCUMULATOR_ALU_WITH_FLAGS_DEFINES_SVH
`define CPU_ACCUMULATOR_ALU_WITH_FLAGS_DEFINES_SVH

// same-cycle implication
`define CAF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CAF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/caf_pkg.sv =====
// shared types, command codes and constants for the accumulator alu
// used by caf_alu and cpu_accumulator_alu_with_flags
package caf_pkg;

  localparam logic [4:0] CMD_ADD   = 5'd0;
  localparam logic [4:0] CMD_ADC   = 5'd1;
  localparam logic [4:0] CMD_SUB   = 5'd2;
  localparam logic [4:0] CMD_SBC   = 5'd3;
  localparam logic [4:0] CMD_AND   = 5'd4;
  localparam logic [4:0] CMD_OR    = 5'd5;
  localparam logic [4:0] CMD_XOR   = 5'd6;
  localparam logic [4:0] CMD_CP    = 5'd7;
  localparam logic [4:0] CMD_INC   = 5'd8;
  localparam logic [4:0] CMD_DEC   = 5'd9;
  localparam logic [4:0] CMD_RLCA  = 5'd10;
  localparam logic [4:0] CMD_RRCA  = 5'd11;
  localparam logic [4:0] CMD_RLA   = 5'd12;
  localparam logic [4:0] CMD_RRA   = 5'd13;
  localparam logic [4:0] CMD_CPL   = 5'd14;
  localparam logic [4:0] CMD_CCF   = 5'd15;
  localparam logic [4:0] CMD_DAA   = 5'd16;
  localparam logic [4:0] CMD_ADDHL = 5'd17;

  localparam logic [7:0] DAA_HI_LIMIT = 8'h99;
  localparam logic [3:0] DAA_LO_LIMIT = 4'h9;
  localparam logic [7:0] DAA_ADJ_HI   = 8'h60;
  localparam logic [7:0] DAA_ADJ_LO   = 8'h06;

  typedef struct packed {
    logic [4:0]  cmd;
    logic [7:0]  operand_byte;
    logic [15:0] hl_value;
    logic [15:0] operand_word;
  } caf_in_t;

  typedef struct packed {
    logic [7:0]  acc_out;
    logic        zero_flag;
    logic        subtract_flag;
    logic        half_carry_flag;
    logic        carry_flag;
    logic [7:0]  register_result;
    logic [15:0] hl_result;
  } caf_out_t;

  typedef struct packed {
    logic z;
    logic n;
    logic h;
    logic c;
  } caf_flags_t;

endpackage

// ===== sv/caf_alu.sv =====
// combinational datapath: one command applied to accumulator and flags
// depends on caf_pkg
module caf_alu (
  input  caf_pkg::caf_in_t    item,
  input  logic [7:0]          acc,
  input  caf_pkg::caf_flags_t flags,
  output caf_pkg::caf_out_t   res
);
  import caf_pkg::*;

  logic        ci;
  logic        bi;
  logic [8:0]  sum9;
  logic [4:0]  hsum5;
  logic [8:0]  diff9;
  logic [4:0]  hdiff5;
  logic [16:0] sum17;
  logic [12:0] hsum13;
  logic [7:0]  and_v;
  logic [7:0]  or_v;
  logic [7:0]  xor_v;
  logic [7:0]  inc_v;
  logic [7:0]  dec_v;
  logic        daa_hi;
  logic        daa_lo;
  logic [7:0]  daa_adj;
  logic [7:0]  daa_v;
  logic        daa_c;

  assign ci = (item.cmd == CMD_ADC) & flags.c;
  assign bi = (item.cmd == CMD_SBC) & flags.c;

  assign sum9   = {1'b0, acc} + {1'b0, item.operand_byte} + {8'd0, ci};
  assign hsum5  = {1'b0, acc[3:0]} + {1'b0, item.operand_byte[3:0]} + {4'd0, ci};
  assign diff9  = {1'b0, acc} - {1'b0, item.operand_byte} - {8'd0, bi};
  assign hdiff5 = {1'b0, acc[3:0]} - {1'b0, item.operand_byte[3:0]} - {4'd0, bi};
  assign sum17  = {1'b0, item.hl_value} + {1'b0, item.operand_word};
  assign hsum13 = {1'b0, item.hl_value[11:0]} + {1'b0, item.operand_word[11:0]};

  assign and_v = acc & item.operand_byte;
  assign or_v  = acc | item.operand_byte;
  assign xor_v = acc ^ item.operand_byte;
  assign inc_v = item.operand_byte + 8'd1;
  assign dec_v = item.operand_byte - 8'd1;

  // decimal adjust follows the n flag
  assign daa_hi  = flags.n ? flags.c : (flags.c | (acc > DAA_HI_LIMIT));
  assign daa_lo  = flags.n ? flags.h : (flags.h | (acc[3:0] > DAA_LO_LIMIT));
  assign daa_adj = (daa_hi ? DAA_ADJ_HI : 8'h00) | (daa_lo ? DAA_ADJ_LO : 8'h00);
  assign daa_v   = flags.n ? (acc - daa_adj) : (acc + daa_adj);
  assign daa_c   = daa_hi;

  always_comb begin
    res.acc_out         = acc;
    res.zero_flag       = flags.z;
    res.subtract_flag   = flags.n;
    res.half_carry_flag = flags.h;
    res.carry_flag      = flags.c;
    res.register_result = 8'h00;
    res.hl_result       = 16'h0000;
    unique case (item.cmd) inside
      CMD_ADD, CMD_ADC: begin
        res.acc_out         = sum9[7:0];
        res.zero_flag       = (sum9[7:0] == 8'h00);
        res.subtract_flag   = 1'b0;
        res.half_carry_flag = hsum5[4];
        res.carry_flag      = sum9[8];
      end
      CMD_SUB, CMD_SBC, CMD_CP: begin
        if (item.cmd != CMD_CP) begin
          res.acc_out = diff9[7:0];
        end
        res.zero_flag       = (diff9[7:0] == 8'h00);
        res.subtract_flag   = 1'b1;
        res.half_carry_flag = hdiff5[4];
        res.carry_flag      = diff9[8];
      end
      CMD_AND: begin
        res.acc_out         = and_v;
        res.zero_flag       = (and_v == 8'h00);
        res.subtract_flag   = 1'b0;
        res.half_carry_flag = 1'b1;
        res.carry_flag      = 1'b0;
      end
      CMD_OR: begin
        res.acc_out         = or_v;
        res.zero_flag       = (or_v == 8'h00);
        res.subtract_flag   = 1'b0;
        res.half_carry_flag = 1'b0;
        res.carry_flag      = 1'b0;
      end
      CMD_XOR: begin
        res.acc_out         = xor_v;
        res.zero_flag       = (xor_v == 8'h00);
        res.subtract_flag   = 1'b0;
        res.half_carry_flag = 1'b0;
        res.carry_flag      = 1'b0;
      end
      CMD_INC: begin
        res.register_result = inc_v;
        res.zero_flag       = (inc_v == 8'h00);
        res.subtract_flag   = 1'b0;
        res.half_carry_flag = (item.operand_byte[3:0] == 4'hF);
      end
      CMD_DEC: begin
        res.register_result = dec_v;
        res.zero_flag       = (dec_v == 8'h00);
        res.subtract_flag   = 1'b1;
        res.half_carry_flag = (item.operand_byte[3:0] == 4'h0);
      end
      CMD_RLCA, CMD_RLA: begin
        res.acc_out         = {acc[6:0], (item.cmd == CMD_RLA) ? flags.c : acc[7]};
        res.zero_flag       = 1'b0;
        res.subtract_flag   = 1'b0;
        res.half_carry_flag = 1'b0;
        res.carry_flag      = acc[7];
      end
      CMD_RRCA, CMD_RRA: begin
        res.acc_out         = {(item.cmd == CMD_RRA) ? flags.c : acc[0], acc[7:1]};
        res.zero_flag       = 1'b0;
        res.subtract_flag   = 1'b0;
        res.half_carry_flag = 1'b0;
        res.carry_flag      = acc[0];
      end
      CMD_CPL: begin
        res.acc_out         = ~acc;
        res.subtract_flag   = 1'b1;
        res.half_carry_flag = 1'b1;
      end
      CMD_CCF: begin
        res.subtract_flag   = 1'b0;
        res.half_carry_flag = 1'b0;
        res.carry_flag      = ~flags.c;
      end
      CMD_DAA: begin
        res.acc_out         = daa_v;
        res.zero_flag       = (daa_v == 8'h00);
        res.half_carry_flag = 1'b0;
        res.carry_flag      = daa_c;
      end
      CMD_ADDHL: begin
        res.hl_result       = sum17[15:0];
        res.subtract_flag   = 1'b0;
        res.half_carry_flag = hsum13[12];
        res.carry_flag      = sum17[16];
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== sv/cpu_accumulator_alu_with_flags.sv =====
// accumulator alu top level: input register, datapath, result register
// depends on caf_pkg, caf_alu and cpu_accumulator_alu_with_flags_defines.svh
// an item is held in the input register, then its result in the result register until taken
// throughput: one item per cycle, held back only by out_stall
// reset (synchronous, rst_n low) clears accumulator, flags and both valid bits
`include "cpu_accumulator_alu_with_flags_defines.svh"

module cpu_accumulator_alu_with_flags (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  caf_pkg::caf_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output caf_pkg::caf_out_t out_data
);
  import caf_pkg::*;

  logic       s1_valid_r;
  logic       s1_valid_nxt;
  caf_in_t    s1_data_r;
  logic       out_valid_r;
  logic       out_valid_nxt;
  caf_out_t   out_data_r;
  logic [7:0] acc_r;
  caf_flags_t flg_r;
  caf_out_t   alu_res;
  logic       s1_adv;
  logic       in_take;

  caf_alu u_alu (
    .item  (s1_data_r),
    .acc   (acc_r),
    .flags (flg_r),
    .res   (alu_res)
  );

  assign s1_adv   = s1_valid_r & (~out_valid_r | ~out_stall);
  assign in_stall = s1_valid_r & ~s1_adv;
  assign in_take  = in_valid & ~in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r & ~out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      acc_r       <= 8'h00;
      flg_r       <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_adv) begin
        acc_r   <= alu_res.acc_out;
        flg_r.z <= alu_res.zero_flag;
        flg_r.n <= alu_res.subtract_flag;
        flg_r.h <= alu_res.half_carry_flag;
        flg_r.c <= alu_res.carry_flag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_data_r <= in_data;
    end
    if (s1_adv) begin
      out_data_r <= alu_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `CAF_ASSERT_NEXT(a_state_hold, !s1_adv, $stable(acc_r) && $stable(flg_r), "state moved")
  `CAF_ASSERT_NEXT(a_res_acc, s1_adv, out_valid_r && out_data_r.acc_out == acc_r, "acc mismatch")
  `CAF_ASSERT_NOW(a_stall_cause, in_stall, s1_valid_r && out_valid_r && out_stall, "bad stall")

endmodule

// ===== verif/tb_cpu_accumulator_alu_with_flags.sv =====
// testbench for cpu_accumulator_alu_with_flags: directed and random alu commands,
// predicted in-line and checked per transfer under random and long output stalls
// depends on caf_pkg and the cpu_accumulator_alu_with_flags rtl
module tb_cpu_accumulator_alu_with_flags;
  timeunit 1ns;
  timeprecision 1ps;

  import caf_pkg::*;

  localparam logic [4:0] CMD_UNDEF_FIRST = CMD_ADDHL + 5'd1;
  localparam logic [4:0] CMD_UNDEF_LAST  = 5'd31;
  localparam int LONG_HOLD   = 60;
  localparam int MAX_REPORTS = 40;
  localparam int PHASE_ITEMS = 430;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  caf_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  caf_out_t out_data;

  logic [7:0] model_acc   = 8'h00;
  caf_flags_t model_flags = '0;
  caf_out_t   pending_results[$];
  int         mismatch_count = 0;
  int         src_idle_pct   = 0;
  int         sink_idle_pct  = 0;
  int         hold_req       = 0;
  int         hold_ack       = 0;
  int         hold_left      = 0;

  cpu_accumulator_alu_with_flags i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #4_000_000;
    $display("cpu_accumulator_alu_with_flags: mismatch");
    $finish;
  end

  // applies one command to the accumulator and flags, returns the result it gives
  function automatic caf_out_t alu_result_for(input caf_in_t it);
    logic [8:0]  sum9;
    logic [4:0]  nib;
    logic [16:0] sum17;
    logic [12:0] sum13;
    logic        cin;
    logic        cy;
    logic [7:0]  a;
    caf_flags_t  f;
    caf_out_t    r;
    a = model_acc;
    f = model_flags;
    r = '0;
    case (it.cmd)
      CMD_ADD, CMD_ADC: begin
        cin  = (it.cmd == CMD_ADC) ? f.c : 1'b0;
        sum9 = {1'b0, a} + {1'b0, it.operand_byte} + {8'h00, cin};
        nib  = {1'b0, a[3:0]} + {1'b0, it.operand_byte[3:0]} + {4'h0, cin};
        a    = sum9[7:0];
        f    = {a == 8'h00, 1'b0, nib[4], sum9[8]};
      end
      CMD_SUB, CMD_SBC, CMD_CP: begin
        cin  = (it.cmd == CMD_SBC) ? f.c : 1'b0;
        sum9 = {1'b0, a} - {1'b0, it.operand_byte} - {8'h00, cin};
        nib  = {1'b0, a[3:0]} - {1'b0, it.operand_byte[3:0]} - {4'h0, cin};
        f    = {sum9[7:0] == 8'h00, 1'b1, nib[4], sum9[8]};
        if (it.cmd != CMD_CP) a = sum9[7:0];
      end
      CMD_AND: begin
        a = a & it.operand_byte;
        f = {a == 8'h00, 1'b0, 1'b1, 1'b0};
      end
      CMD_OR: begin
        a = a | it.operand_byte;
        f = {a == 8'h00, 3'b000};
      end
      CMD_XOR: begin
        a = a ^ it.operand_byte;
        f = {a == 8'h00, 3'b000};
      end
      CMD_INC: begin
        r.register_result = it.operand_byte + 8'h01;
        f = {r.register_result == 8'h00, 1'b0, it.operand_byte[3:0] == 4'hF, f.c};
      end
      CMD_DEC: begin
        r.register_result = it.operand_byte - 8'h01;
        f = {r.register_result == 8'h00, 1'b1, it.operand_byte[3:0] == 4'h0, f.c};
      end
      CMD_RLCA: begin
        f = {3'b000, a[7]};
        a = {a[6:0], a[7]};
      end
      CMD_RRCA: begin
        f = {3'b000, a[0]};
        a = {a[0], a[7:1]};
      end
      CMD_RLA: begin
        cin = f.c;
        f   = {3'b000, a[7]};
        a   = {a[6:0], cin};
      end
      CMD_RRA: begin
        cin = f.c;
        f   = {3'b000, a[0]};
        a   = {cin, a[7:1]};
      end
      CMD_CPL: begin
        a   = ~a;
        f.n = 1'b1;
        f.h = 1'b1;
      end
      CMD_CCF: begin
        f = {f.z, 1'b0, 1'b0, ~f.c};
      end
      CMD_DAA: begin
        cy = f.c;
        if (!f.n) begin
          if (cy || a > DAA_HI_LIMIT) begin
            a  = a + DAA_ADJ_HI;
            cy = 1'b1;
          end
          if (f.h || a[3:0] > DAA_LO_LIMIT) a = a + DAA_ADJ_LO;
        end else begin
          if (cy) a = a - DAA_ADJ_HI;
          if (f.h) a = a - DAA_ADJ_LO;
        end
        f = {a == 8'h00, f.n, 1'b0, cy};
      end
      CMD_ADDHL: begin
        sum17 = {1'b0, it.hl_value} + {1'b0, it.operand_word};
        sum13 = {1'b0, it.hl_value[11:0]} + {1'b0, it.operand_word[11:0]};
        r.hl_result = sum17[15:0];
        f = {f.z, 1'b0, sum13[12], sum17[16]};
      end
      default: begin
      end
    endcase
    model_acc         = a;
    model_flags       = f;
    r.acc_out         = a;
    r.zero_flag       = f.z;
    r.subtract_flag   = f.n;
    r.half_carry_flag = f.h;
    r.carry_flag      = f.c;
    return r;
  endfunction

  function automatic caf_in_t op_item(input logic [4:0] c, input logic [7:0] b,
                                      input logic [15:0] hl, input logic [15:0] w);
    caf_in_t it;
    it.cmd          = c;
    it.operand_byte = b;
    it.hl_value     = hl;
    it.operand_word = w;
    return it;
  endfunction

  function automatic caf_in_t random_item();
    caf_in_t it;
    if ($urandom_range(0, 99) < 6)
      it.cmd = 5'($urandom_range(CMD_UNDEF_FIRST, CMD_UNDEF_LAST));
    else
      it.cmd = 5'($urandom_range(CMD_ADD, CMD_ADDHL));
    case ($urandom_range(0, 7))
      0:       it.operand_byte = 8'h00;
      1:       it.operand_byte = 8'hFF;
      2:       it.operand_byte = {4'($urandom), 4'hF};
      3:       it.operand_byte = {4'($urandom), 4'h0};
      default: it.operand_byte = 8'($urandom);
    endcase
    it.hl_value     = 16'($urandom);
    it.operand_word = 16'($urandom);
    if ($urandom_range(0, 3) == 0) it.hl_value[11:0] = 12'hFFF;
    return it;
  endfunction

  // output side: random stalls plus long holds on request
  always @(negedge clk) begin
    if (hold_ack != hold_req) begin
      hold_ack  = hold_req;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < sink_idle_pct);
    end
  end

  always @(posedge clk) begin
    caf_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t unexpected transfer expected none actual %h", $time, out_data);
      end else begin
        want = pending_results.pop_front();
        if (want !== out_data) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("%0t result expected %h actual %h", $time, want, out_data);
        end
      end
    end
  end

  // called and returns at a falling edge
  task automatic send_item(input caf_in_t it);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(alu_result_for(it));
    @(negedge clk);
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic test_directed_ops();
    src_idle_pct = 0;
    sink_idle_pct <= 0;
    send_item(op_item(CMD_ADD, 8'hFF, 16'h0000, 16'h0000));
    send_item(op_item(CMD_ADD, 8'h01, 16'h0000, 16'h0000));
    send_item(op_item(CMD_ADC, 8'hFF, 16'h0000, 16'h0000));
    send_item(op_item(CMD_SUB, 8'h01, 16'h0000, 16'h0000));
    send_item(op_item(CMD_SBC, 8'hFF, 16'h0000, 16'h0000));
    send_item(op_item(CMD_CP, 8'h80, 16'h0000, 16'h0000));
    send_item(op_item(CMD_AND, 8'h0F, 16'h0000, 16'h0000));
    send_item(op_item(CMD_OR, 8'hF0, 16'h0000, 16'h0000));
    send_item(op_item(CMD_XOR, 8'hFF, 16'h0000, 16'h0000));
    send_item(op_item(CMD_INC, 8'hFF, 16'h0000, 16'h0000));
    send_item(op_item(CMD_DEC, 8'h00, 16'h0000, 16'h0000));
    send_item(op_item(CMD_RLCA, 8'h00, 16'h0000, 16'h0000));
    send_item(op_item(CMD_RRCA, 8'h00, 16'h0000, 16'h0000));
    send_item(op_item(CMD_RLA, 8'h00, 16'h0000, 16'h0000));
    send_item(op_item(CMD_RRA, 8'h00, 16'h0000, 16'h0000));
    send_item(op_item(CMD_CPL, 8'h00, 16'h0000, 16'h0000));
    send_item(op_item(CMD_CCF, 8'h00, 16'h0000, 16'h0000));
    // decimal adjust after an add, then after a subtract
    send_item(op_item(CMD_AND, 8'h00, 16'h0000, 16'h0000));
    send_item(op_item(CMD_ADD, 8'h9A, 16'h0000, 16'h0000));
    send_item(op_item(CMD_DAA, 8'h00, 16'h0000, 16'h0000));
    send_item(op_item(CMD_SUB, 8'h01, 16'h0000, 16'h0000));
    send_item(op_item(CMD_DAA, 8'h00, 16'h0000, 16'h0000));
    send_item(op_item(CMD_ADDHL, 8'h00, 16'hFFFF, 16'h0001));
    send_item(op_item(CMD_ADDHL, 8'h00, 16'h0800, 16'h0800));
    // undefined commands leave the state alone
    send_item(op_item(CMD_UNDEF_LAST, 8'hFF, 16'hFFFF, 16'hFFFF));
    send_item(op_item(CMD_UNDEF_FIRST, 8'h00, 16'h0000, 16'h0000));
    wait_for_drain();
  endtask

  task automatic test_random_traffic(input int n_items, input int src_pct, input int sink_pct);
    int      sent;
    caf_in_t it;
    src_idle_pct = src_pct;
    sink_idle_pct <= sink_pct;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) == 0) begin
        // bcd arithmetic followed by decimal adjust
        it = random_item();
        case ($urandom_range(0, 3))
          0:       it.cmd = CMD_ADD;
          1:       it.cmd = CMD_ADC;
          2:       it.cmd = CMD_SUB;
          default: it.cmd = CMD_SBC;
        endcase
        it.operand_byte = {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
        send_item(it);
        it.cmd = CMD_DAA;
        send_item(it);
        sent += 2;
      end else begin
        send_item(random_item());
        sent++;
      end
    end
    wait_for_drain();
  endtask

  task automatic test_output_hold();
    src_idle_pct = 0;
    sink_idle_pct <= 0;
    hold_req <= hold_req + 1;
    repeat (30) send_item(random_item());
    wait_for_drain();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed_ops();
    test_random_traffic(PHASE_ITEMS, 38, 50);
    test_output_hold();
    test_random_traffic(PHASE_ITEMS, 50, 38);
    test_random_traffic(PHASE_ITEMS, 0, 0);
    wait_for_drain();
    repeat (8) @(negedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("cpu_accumulator_alu_with_flags: match");
    end else begin
      $display("cpu_accumulator_alu_with_flags: mismatch");
    end
    $finish;
  end

endmodule
